FILE: hw/rtl/tkpd_pkg.sv
`default_nettype none
package tkpd_pkg;

  localparam int KEYS_MAX     = 4;
  localparam int NUM_KEYS_DEF = 4;
  localparam int CNT_W        = 16;
  localparam int TIME_W       = 12;
  localparam int MASK_W       = 4;
  localparam int FILT_W       = 18;
  localparam int CFG_IDX_W    = 3;

  localparam logic [TIME_W-1:0] SHORT_MIN_TIME = TIME_W'(5);

  localparam logic [CNT_W-1:0]  THRESHOLD_RST  = CNT_W'(200);
  localparam logic [TIME_W-1:0] SHORT_LIM_RST  = TIME_W'(800);
  localparam logic [TIME_W-1:0] HOLD_START_RST = TIME_W'(100);
  localparam logic [TIME_W-1:0] LONG_LIM_RST   = TIME_W'(2000);

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE0  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE1  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE2  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE3  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIM  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_START = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIM   = CFG_IDX_W'(7);

  typedef struct packed {
    logic [TIME_W-1:0] short_limit;
    logic [TIME_W-1:0] hold_start;
    logic [TIME_W-1:0] long_limit;
  } timing_t;

  typedef struct packed {
    logic [MASK_W-1:0] pressed_mask;
    logic [MASK_W-1:0] short_mask;
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] long_mask;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tkpd_lane.sv
`default_nettype none
module tkpd_lane
  import tkpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             scan_load,
  input  wire logic [CNT_W-1:0] baseline,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [CNT_W-1:0] threshold,
  output logic                  pressed
);

  localparam int SUM_W = FILT_W + 2;

  logic signed [FILT_W-1:0] filt_r;
  logic signed [FILT_W-1:0] filt_nxt;
  logic signed [CNT_W:0]    delta;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_adj;

  assign delta = $signed({1'b0, baseline}) - $signed({1'b0, count});

  // 3*old as old + 2*old
  assign sum = SUM_W'(delta) + SUM_W'(filt_r) + (SUM_W'(filt_r) <<< 1);

  // round toward zero: bias negatives by 3 before the arithmetic shift
  assign sum_adj  = sum + (sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
  assign filt_nxt = FILT_W'(sum_adj >>> 2);

  assign pressed = filt_nxt > $signed({{(FILT_W-CNT_W){1'b0}}, threshold});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (scan_load) begin
      filt_r <= filt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tkpd_merge.sv
`default_nettype none
module tkpd_merge
  import tkpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_load,
  input  wire logic              is_tick,
  input  wire logic [MASK_W-1:0] lane_mask,
  input  wire timing_t           timing,
  output result_t                result
);

  logic [MASK_W-1:0] pressed_r, short_r, held_r, long_r;
  logic [MASK_W-1:0] pressed_nxt, short_nxt, held_nxt, long_nxt;
  logic [TIME_W-1:0] timer_r, timer_nxt;
  logic [TIME_W-1:0] t_clr;

  always_comb begin
    pressed_nxt = pressed_r;
    short_nxt   = short_r;
    held_nxt    = held_r;
    long_nxt    = long_r;
    timer_nxt   = timer_r;
    t_clr       = timer_r;
    if (is_tick) begin
      if (timer_r < timing.long_limit) begin
        timer_nxt = timer_r + TIME_W'(1);
      end else begin
        timer_nxt = timing.long_limit;
      end
    end else begin
      if (lane_mask == '0) begin
        // release: report a short press if the key was down longer than the minimum and under the short limit
        if (timer_r > SHORT_MIN_TIME && timer_r < timing.short_limit) begin
          short_nxt = pressed_r;
        end else begin
          short_nxt = '0;
        end
        held_nxt = '0;
        long_nxt = '0;
        t_clr    = '0;
      end
      timer_nxt = t_clr;
      if (t_clr > timing.hold_start) begin
        held_nxt = lane_mask;
      end
      if (t_clr >= timing.long_limit) begin
        timer_nxt = timing.long_limit;
        long_nxt  = lane_mask;
      end
      pressed_nxt = lane_mask;
    end
  end

  assign result = '{pressed_mask: pressed_nxt, short_mask: short_nxt,
                    held_mask: held_nxt, long_mask: long_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
      short_r   <= '0;
      held_r    <= '0;
      long_r    <= '0;
      timer_r   <= '0;
    end else if (item_load) begin
      pressed_r <= pressed_nxt;
      short_r   <= short_nxt;
      held_r    <= held_nxt;
      long_r    <= long_nxt;
      timer_r   <= timer_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/touch_key_press_detector.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid/in_ready   | cmd, count_key0..3
// out_    | output    | out_valid/out_ready | pressed/short/held/long masks
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index (0..7), cfg_data
//
// One item per cycle while the output buffer has room: each key's filter lane
// and the mask/timer merge settle in the cycle the item is accepted, and the
// result enters a two-entry output buffer at that edge, behind any unread
// result. in_ready drops only when both buffer entries hold unread results.
// Synchronous active-low reset clears filters, masks, timer and buffer and
// restores the register defaults. cfg_ready is always high.
`default_nettype none
module touch_key_press_detector
  import tkpd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_cmd,
  input  wire logic [CNT_W-1:0]     in_count_key0,
  input  wire logic [CNT_W-1:0]     in_count_key1,
  input  wire logic [CNT_W-1:0]     in_count_key2,
  input  wire logic [CNT_W-1:0]     in_count_key3,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [MASK_W-1:0]         out_pressed_mask,
  output logic [MASK_W-1:0]         out_short_mask,
  output logic [MASK_W-1:0]         out_held_mask,
  output logic [MASK_W-1:0]         out_long_mask,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  // keys above the four count inputs are never pressed
  localparam int LANES = (NUM_KEYS < KEYS_MAX) ? NUM_KEYS : KEYS_MAX;

  logic [CNT_W-1:0] baseline_r [KEYS_MAX];
  logic [CNT_W-1:0] threshold_r;
  timing_t          timing_r;

  logic [CNT_W-1:0]  count [KEYS_MAX];
  logic [MASK_W-1:0] lane_mask;
  logic              in_acc, out_acc, scan_load;
  result_t           result;

  result_t     buf0_r, buf1_r;
  logic [1:0]  fill_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEYS_MAX; k++) begin
        baseline_r[k] <= '0;
      end
      threshold_r          <= THRESHOLD_RST;
      timing_r.short_limit <= SHORT_LIM_RST;
      timing_r.hold_start  <= HOLD_START_RST;
      timing_r.long_limit  <= LONG_LIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASELINE0:  baseline_r[0] <= cfg_data;
        REG_BASELINE1:  baseline_r[1] <= cfg_data;
        REG_BASELINE2:  baseline_r[2] <= cfg_data;
        REG_BASELINE3:  baseline_r[3] <= cfg_data;
        REG_THRESHOLD:  threshold_r <= cfg_data;
        REG_SHORT_LIM:  timing_r.short_limit <= cfg_data[TIME_W-1:0];
        REG_HOLD_START: timing_r.hold_start <= cfg_data[TIME_W-1:0];
        REG_LONG_LIM:   timing_r.long_limit <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign count[0] = in_count_key0;
  assign count[1] = in_count_key1;
  assign count[2] = in_count_key2;
  assign count[3] = in_count_key3;

  assign in_ready  = (fill_r != 2'd2);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (fill_r != 2'd0);
  assign out_acc   = out_valid && out_ready;
  assign scan_load = in_acc && !in_cmd;

  for (genvar k = 0; k < KEYS_MAX; k++) begin : g_lane
    if (k < LANES) begin : g_on
      tkpd_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_load (scan_load),
        .baseline  (baseline_r[k]),
        .count     (count[k]),
        .threshold (threshold_r),
        .pressed   (lane_mask[k])
      );
    end else begin : g_off
      assign lane_mask[k] = 1'b0;
    end
  end

  tkpd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_load (in_acc),
    .is_tick   (in_cmd),
    .lane_mask (lane_mask),
    .timing    (timing_r),
    .result    (result)
  );

  // two-entry result buffer, buf0 is the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({in_acc, out_acc})
      2'b10: begin
        if (fill_r == 2'd0) begin
          buf0_r <= result;
        end else begin
          buf1_r <= result;
        end
      end
      2'b01: begin
        buf0_r <= buf1_r;
      end
      2'b11: begin
        if (fill_r == 2'd1) begin
          buf0_r <= result;
        end else begin
          buf0_r <= buf1_r;
          buf1_r <= result;
        end
      end
      default: ;
    endcase
  end

  assign out_pressed_mask = buf0_r.pressed_mask;
  assign out_short_mask   = buf0_r.short_mask;
  assign out_held_mask    = buf0_r.held_mask;
  assign out_long_mask    = buf0_r.long_mask;

endmodule
`default_nettype wire

FILE: test/tkpd_tb_pkg.sv
package tkpd_tb_pkg;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_TICK = 1'b1
  } key_cmd_e;

endpackage

FILE: test/tkpd_mask_checker.sv
module tkpd_mask_checker
  import tkpd_pkg::*, tkpd_tb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic                 in_cmd,
  input  wire logic [CNT_W-1:0]     in_count_key0,
  input  wire logic [CNT_W-1:0]     in_count_key1,
  input  wire logic [CNT_W-1:0]     in_count_key2,
  input  wire logic [CNT_W-1:0]     in_count_key3,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [MASK_W-1:0]    out_pressed_mask,
  input  wire logic [MASK_W-1:0]    out_short_mask,
  input  wire logic [MASK_W-1:0]    out_held_mask,
  input  wire logic [MASK_W-1:0]    out_long_mask,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy
  logic [CNT_W-1:0]  baseline [KEYS_MAX];
  logic [CNT_W-1:0]  threshold;
  timing_t           timing;

  // detector state
  logic signed [FILT_W-1:0] filt [KEYS_MAX];
  logic [MASK_W-1:0] pressed_q, last_mask, short_q, held_q, long_q;
  logic [TIME_W-1:0] timer_q;

  result_t expected_masks [$];
  int      fail_count = 0;

  assign mismatches = fail_count;

  task automatic report(input string msg);
    fail_count++;
    $display("%t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [MASK_W-1:0] got, want);
    if (got !== want)
      report($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  task automatic reset_detector();
    for (int k = 0; k < KEYS_MAX; k++) begin
      baseline[k] = '0;
      filt[k]     = '0;
    end
    threshold          = THRESHOLD_RST;
    timing.short_limit = SHORT_LIM_RST;
    timing.hold_start  = HOLD_START_RST;
    timing.long_limit  = LONG_LIM_RST;
    pressed_q = '0;
    last_mask = '0;
    short_q   = '0;
    held_q    = '0;
    long_q    = '0;
    timer_q   = '0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    case (idx)
      REG_BASELINE0, REG_BASELINE1, REG_BASELINE2, REG_BASELINE3: begin
        baseline[idx] = data;
      end
      REG_THRESHOLD:  threshold          = data;
      REG_SHORT_LIM:  timing.short_limit = data[TIME_W-1:0];
      REG_HOLD_START: timing.hold_start  = data[TIME_W-1:0];
      REG_LONG_LIM:   timing.long_limit  = data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // Advances the detector by one item and returns the masks it shows.
  function automatic result_t step_detector(input logic cmd,
                                            input logic [KEYS_MAX*CNT_W-1:0] counts);
    int delta;
    int acc;
    int nv;
    logic [MASK_W-1:0] mask;
    result_t r;
    mask = '0;
    if (cmd == CMD_TICK) begin
      if (timer_q < timing.long_limit) timer_q = timer_q + 1'b1;
      else timer_q = timing.long_limit;
    end else begin
      for (int k = 0; k < KEYS_MAX; k++) begin
        delta = int'(baseline[k]) - int'(counts[k*CNT_W +: CNT_W]);
        acc   = delta + 3 * int'(filt[k]);
        nv    = acc / 4;  // truncates toward zero
        filt[k] = FILT_W'(nv);
        if (nv > int'(threshold)) mask[k] = 1'b1;
      end
      if (mask == '0) begin
        short_q = (timer_q > SHORT_MIN_TIME && timer_q < timing.short_limit) ? last_mask : '0;
        held_q  = '0;
        long_q  = '0;
        timer_q = '0;
      end
      if (timer_q > timing.hold_start) held_q = mask;
      if (timer_q >= timing.long_limit) begin
        timer_q = timing.long_limit;
        long_q  = mask;
      end
      last_mask = mask;
      pressed_q = mask;
    end
    r.pressed_mask = pressed_q;
    r.short_mask   = short_q;
    r.held_mask    = held_q;
    r.long_mask    = long_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      reset_detector();
      expected_masks.delete();
    end else begin
      // a result never leaves in the cycle its item enters, so pop before push
      if (out_valid && out_ready) begin
        if (expected_masks.size() == 0) begin
          report($sformatf("result with nothing expected: %h %h %h %h", out_pressed_mask,
                           out_short_mask, out_held_mask, out_long_mask));
        end else begin
          want = expected_masks.pop_front();
          check_field("pressed_mask", out_pressed_mask, want.pressed_mask);
          check_field("short_mask", out_short_mask, want.short_mask);
          check_field("held_mask", out_held_mask, want.held_mask);
          check_field("long_mask", out_long_mask, want.long_mask);
        end
      end
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        expected_masks.push_back(step_detector(in_cmd, {in_count_key3, in_count_key2,
                                                        in_count_key1, in_count_key0}));
    end
    awaited <= expected_masks.size();
  end

endmodule

FILE: test/tb_touch_key_press_detector.sv
module tb_touch_key_press_detector
  import tkpd_pkg::*, tkpd_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 210;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_SCAN;
  logic [CNT_W-1:0]     in_count_key0 = '0;
  logic [CNT_W-1:0]     in_count_key1 = '0;
  logic [CNT_W-1:0]     in_count_key2 = '0;
  logic [CNT_W-1:0]     in_count_key3 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MASK_W-1:0]    out_pressed_mask, out_short_mask, out_held_mask, out_long_mask;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  int                   mismatches;
  int                   awaited;

  bit                   calm = 1'b0;
  int                   items_sent = 0;
  int                   quiet_cycles = 0;

  // settings in force, used to shape key counts and hold lengths
  logic [CNT_W-1:0]     base_cfg [KEYS_MAX] = '{default: '0};
  logic [CNT_W-1:0]     thr_cfg = THRESHOLD_RST;
  logic [TIME_W-1:0]    long_cfg = LONG_LIM_RST;

  touch_key_press_detector u_top (.*);
  tkpd_mask_checker u_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 32);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input key_cmd_e cmd, input logic [CNT_W-1:0] c0, c1, c2, c3);
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 32);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_count_key0 <= c0;
    in_count_key1 <= c1;
    in_count_key2 <= c2;
    in_count_key3 <= c3;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic scan(input logic [CNT_W-1:0] c0, c1, c2, c3);
    send_item(CMD_SCAN, c0, c1, c2, c3);
  endtask

  // counts are ignored on a tick, so they carry noise
  task automatic tick();
    send_item(CMD_TICK, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
              CNT_W'($urandom));
  endtask

  // hold off until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input logic [CNT_W-1:0] b0, b1, b2, b3, thr,
                              input logic [TIME_W-1:0] sl, hs, ll);
    settle();
    write_reg(REG_BASELINE0, b0);
    write_reg(REG_BASELINE1, b1);
    write_reg(REG_BASELINE2, b2);
    write_reg(REG_BASELINE3, b3);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_SHORT_LIM, CNT_W'(sl));
    write_reg(REG_HOLD_START, CNT_W'(hs));
    write_reg(REG_LONG_LIM, CNT_W'(ll));
    cfg_valid <= 1'b0;
    base_cfg = '{b0, b1, b2, b3};
    thr_cfg  = thr;
    long_cfg = ll;
  endtask

  // touched keys sit well past the threshold, others near their baseline
  function automatic logic [CNT_W-1:0] key_count(input int k, input bit touched);
    int thr_i;
    int c;
    thr_i = int'(thr_cfg);
    if (touched)
      c = int'(base_cfg[k]) - int'($urandom_range(2 * thr_i + 50, 4 * thr_i + 200));
    else
      c = int'(base_cfg[k]) + int'($urandom_range(0, 200)) - int'($urandom_range(0, thr_i / 2));
    if (c < 0) c = 0;
    if (c > int'(CNT_MAX)) c = int'(CNT_MAX);
    return CNT_W'(c);
  endfunction

  function automatic logic [CNT_W-1:0] release_count(input int k);
    if ($urandom_range(0, 1) == 0) return base_cfg[k];
    return base_cfg[k] + CNT_W'($urandom_range(0, int'(CNT_MAX - base_cfg[k])));
  endfunction

  task automatic press_scan(input logic [MASK_W-1:0] keys);
    scan(key_count(0, keys[0]), key_count(1, keys[1]), key_count(2, keys[2]),
         key_count(3, keys[3]));
  endtask

  // touch, hold across a random number of ticks, then let go
  task automatic press_episode();
    logic [MASK_W-1:0] keys;
    int hold_ticks;
    keys = MASK_W'($urandom_range(1, 15));
    hold_ticks = $urandom_range(0, (long_cfg > 70) ? 80 : int'(long_cfg) + 8);
    repeat ($urandom_range(1, 4)) press_scan(keys);
    repeat (hold_ticks) begin
      tick();
      if ($urandom_range(0, 99) < 35)
        press_scan(($urandom_range(0, 9) == 0) ? MASK_W'($urandom) : keys);
    end
    repeat ($urandom_range(1, 8))
      scan(release_count(0), release_count(1), release_count(2), release_count(3));
  endtask

  initial begin : stimulus
    int thr;
    int phase_end;
    logic [CNT_W-1:0]  b [KEYS_MAX];
    logic [TIME_W-1:0] sl, hs, ll;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: baselines at zero, so nothing can press
    scan('0, '0, '0, '0);
    scan(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
    tick();
    tick();

    // zero threshold, short timing: press, saturate the timer, long press, release
    write_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, '0, '1, TIME_W'(1), TIME_W'(3));
    repeat (2) scan('0, '0, '0, '0);
    repeat (4) tick();
    scan('0, '0, '0, '0);
    repeat (2) scan(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);

    // zero long limit: timer pinned, every scan copies the mask to long
    write_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, CNT_W'(100), '0, '1, '0);
    repeat (2) scan('0, CNT_MAX, '0, CNT_MAX);
    tick();
    scan('0, CNT_MAX, '0, CNT_MAX);
    repeat (2) scan(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);

    // top threshold can never be passed
    write_config(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, '0, '0, TIME_W'(1));
    repeat (2) scan('0, '0, '0, '0);

    for (int phase = 0; phase < 8; phase++) begin
      thr = $urandom_range(16, 3000);
      foreach (b[k])
        b[k] = (phase == 6) ? CNT_W'($urandom) : CNT_W'($urandom_range(4 * thr + 200, 65535));
      sl = $urandom_range(0, 50);
      hs = $urandom_range(0, 45);
      ll = $urandom_range(1, 60);
      if (phase == 0) begin
        thr = 0;
        b = '{default: CNT_MAX};
      end
      if (phase == 1) begin
        sl = '1;
        hs = '1;
        ll = '1;
      end
      if (phase == 2) begin
        ll = TIME_W'(1);
        hs = '0;
      end
      write_config(b[0], b[1], b[2], b[3], CNT_W'(thr), sl, hs, ll);
      calm = (phase == 3);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 15)
          send_item(key_cmd_e'($urandom_range(0, 1)), CNT_W'($urandom), CNT_W'($urandom),
                    CNT_W'($urandom), CNT_W'($urandom));
        else
          press_episode();
        if ($urandom_range(0, 99) < 4) settle();
      end
    end

    calm = 1'b0;
    settle();
    if (mismatches == 0 && awaited == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
